// ===== hw/rtl/tmrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer bank package
// Operation codes, fixed field widths, register reset values and the channel
// control word shared by the timer bank modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmrb_pkg;

  localparam int OP_W       = 2;
  localparam int CHAN_W     = 2;
  localparam int TICKS_W    = 16;
  localparam int MASK_W     = 4;
  localparam int NUM_RELOAD = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RELOAD_RESET [NUM_RELOAD] = '{
    16'd100, 16'd100, 16'd500, 16'd0
  };

  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
  } chan_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_channel_timeout_timer_bank.sv =====
// ----------------------------------------------------------------------------
// Multi-channel timeout timer bank
// Bank of down-counting timeout channels with per-channel auto-reload.
// ----------------------------------------------------------------------------
// Each input word is a tick, a start of one channel with a timeout, or a stop
// of one channel. Every input word yields exactly one output word carrying the
// mask of channels that expired on that tick and the mask of channels still
// running afterwards. Only channels 0 to 3 appear in the masks.
// Both channels use valid/ready. A word is held in an input register, then
// applied to all channel counters in parallel while the result is captured in
// the output register, which drives out_valid, and one word per cycle is
// sustained while out_ready stays high.
// When the receiver stalls, the output register holds its word and the input
// register can still take one more word; in_ready falls only when both are
// full and out_ready is low.
// Reset clears all counters to idle, empties both registers and loads the
// reload registers with 100, 100, 500 and 0. The user writes them through
// the cfg port only while the bank is idle; the bank does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_timeout_timer_bank #(
  parameter int NUM_CHANNELS = 4,
  parameter int COUNT_BITS   = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [tmrb_pkg::OP_W-1:0]           in_operation,
  input  wire  [tmrb_pkg::CHAN_W-1:0]         in_channel,
  input  wire  [tmrb_pkg::TICKS_W-1:0]        in_timeout_ticks,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [tmrb_pkg::MASK_W-1:0]         out_expired_mask,
  output logic [tmrb_pkg::MASK_W-1:0]         out_running_mask,
  input  wire                                 cfg_wr_en,
  input  wire  [tmrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [tmrb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import tmrb_pkg::*;

  localparam int MASK_CH = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;

  logic                  in_vld_r;
  logic [OP_W-1:0]       op_r;
  logic [CHAN_W-1:0]     ch_r;
  logic [TICKS_W-1:0]    ticks_r;
  logic                  out_vld_r;
  logic [MASK_W-1:0]     exp_mask_r;
  logic [MASK_W-1:0]     run_mask_r;
  logic [CFG_DATA_W-1:0] reload_r [NUM_RELOAD];

  logic                    adv;
  logic                    is_tick;
  logic                    is_start;
  logic                    is_stop;
  logic [COUNT_BITS-1:0]   load_val;
  logic [NUM_CHANNELS-1:0] exp_v;
  logic [NUM_CHANNELS-1:0] run_v;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;
  assign is_tick  = adv && (op_r == OP_TICK);
  assign is_start = adv && (op_r == OP_START);
  assign is_stop  = adv && (op_r == OP_STOP);
  assign load_val = COUNT_BITS'(ticks_r);

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    chan_ctrl_t            ctrl;
    logic                  sel;
    logic [COUNT_BITS-1:0] reload_val;

    assign sel        = (32'(ch_r) == i);
    assign ctrl.tick  = is_tick;
    assign ctrl.start = is_start && sel;
    assign ctrl.stop  = is_stop && sel;

    if (i < NUM_RELOAD) begin : g_rld
      assign reload_val = COUNT_BITS'(reload_r[i]);
    end else begin : g_norld
      assign reload_val = '0;
    end

    tmrb_chan #(
      .COUNT_BITS (COUNT_BITS)
    ) u_chan (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .load_val   (load_val),
      .reload_val (reload_val),
      .expired    (exp_v[i]),
      .running    (run_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_RELOAD; k++) begin
        reload_r[k] <= RELOAD_RESET[k];
      end
    end else if (cfg_wr_en) begin
      reload_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r    <= in_operation;
      ch_r    <= in_channel;
      ticks_r <= in_timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      exp_mask_r <= MASK_W'(exp_v[MASK_CH-1:0]);
      run_mask_r <= MASK_W'(run_v[MASK_CH-1:0]);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_expired_mask = exp_mask_r;
  assign out_running_mask = run_mask_r;

  // The input side only stalls when both registers hold a word and the
  // receiver is not taking one.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // A word moving forward always lands in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced word lost");

  // Only a tick can report expired channels.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (op_r != OP_TICK)) |=> (out_expired_mask == '0))
    else $error("expiry reported on a non-tick word");

  // An expired channel never appears on a word that was not advanced.
  assert property (@(posedge clk) disable iff (!rst_n)
    (exp_v != '0) |-> adv)
    else $error("channel expired without a tick being applied");

endmodule

`default_nettype wire

// ===== hw/rtl/tmrb_chan.sv =====
// ----------------------------------------------------------------------------
// Timer bank channel
// One down-counting channel with auto-reload, start and stop.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrb_chan #(
  parameter int COUNT_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  tmrb_pkg::chan_ctrl_t    ctrl,
  input  wire  [COUNT_BITS-1:0]   load_val,
  input  wire  [COUNT_BITS-1:0]   reload_val,
  output logic                    expired,
  output logic                    running
);

  localparam logic [COUNT_BITS-1:0] ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (ctrl.tick) begin
      if (cnt_r != '0) begin
        if (cnt_r == ONE) begin
          cnt_nxt = reload_val;
        end else begin
          cnt_nxt = cnt_r - ONE;
        end
      end
    end else if (ctrl.start) begin
      cnt_nxt = load_val;
    end else if (ctrl.stop) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign expired = ctrl.tick && (cnt_r == ONE);
  assign running = (cnt_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
